>>> hdl/lmfw_pkg.sv
// Shared types, codes and frame builders for the LED matrix frame writer.
// No dependencies; imported by lmfw_cfg_if and by every module.
package lmfw_pkg;

  localparam int MAX_CHIPS  = 4;
  localparam int FRAME_BITS = 18;
  localparam int CMD_BITS   = 12;
  localparam int CNT_W      = 5;
  localparam int DEV_W      = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_X_DEVICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DEVICES = 2'd1;

  typedef enum logic [1:0] {
    MODE_PLOT    = 2'd0,
    MODE_COLUMN  = 2'd1,
    MODE_COMMAND = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PLOT    = 2'd1,
    OP_COLUMN  = 2'd2,
    OP_COMMAND = 2'd3
  } op_kind_e;

  // decoded item held in the input register
  typedef struct packed {
    op_kind_e    kind;
    logic [1:0]  chip;
    logic [6:0]  addr;
    logic [2:0]  row;
    logic        pixel_set;
    logic [7:0]  data;
  } op_t;

  // serial frame, bit 0 goes out first
  typedef struct packed {
    logic [FRAME_BITS-1:0] bits;
    logic [CNT_W-1:0]      len;
    logic [1:0]            chip;
  } frame_t;

  // 1,0,1, address MSB first, data LSB first
  function automatic frame_t write_frame(logic [1:0] chip, logic [6:0] addr, logic [7:0] data);
    frame_t f;
    f.bits = '0;
    f.bits[0] = 1'b1;
    f.bits[1] = 1'b0;
    f.bits[2] = 1'b1;
    for (int i = 0; i < 7; i++) f.bits[3+i] = addr[6-i];
    for (int i = 0; i < 8; i++) f.bits[10+i] = data[i];
    f.len  = CNT_W'(FRAME_BITS);
    f.chip = chip;
    return f;
  endfunction

  // 1,0,0, command MSB first, trailing 0
  function automatic frame_t cmd_frame(logic [1:0] chip, logic [7:0] code);
    frame_t f;
    f.bits = '0;
    f.bits[0] = 1'b1;
    for (int i = 0; i < 8; i++) f.bits[3+i] = code[7-i];
    f.len  = CNT_W'(CMD_BITS);
    f.chip = chip;
    return f;
  endfunction

endpackage

>>> hdl/lmfw_if.sv
// Handshake channel interfaces: input items, serial output bits, register writes.
// Depends on lmfw_pkg.
interface lmfw_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [7:0] x_position;
  logic signed [6:0] y_position;
  logic              pixel_set;
  logic [7:0]        column_byte;
  logic [1:0]        command_chip;
  logic [7:0]        command_code;

  modport source (output valid, mode, x_position, y_position, pixel_set, column_byte,
                  command_chip, command_code, input ready);
  modport sink (input valid, mode, x_position, y_position, pixel_set, column_byte,
                command_chip, command_code, output ready);
endinterface

interface lmfw_bit_if;
  logic       valid;
  logic       ready;
  logic [1:0] chip_index;
  logic       serial_bit;
  logic       last_bit;

  modport source (output valid, chip_index, serial_bit, last_bit, input ready);
  modport sink (input valid, chip_index, serial_bit, last_bit, output ready);
endinterface

interface lmfw_cfg_if import lmfw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DEV_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/lmfw_front.sv
// Tiling registers, coordinate decode and the input register.
// Depends on lmfw_pkg and lmfw_if.
module lmfw_front import lmfw_pkg::*; #(
  parameter int CHIP_COLUMNS = 32,
  parameter int IDX_W        = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lmfw_item_if.sink        item_i,
  lmfw_cfg_if.sink         cfg_i,
  input  logic             s1_adv_i,
  output logic             s1_valid_o,
  output op_t              s1_op_o,
  output logic [IDX_W-1:0] s1_idx_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_idx_o
);

  logic [DEV_W-1:0] x_dev_q, y_dev_q;
  logic             s1_valid_q, s1_valid_d;
  op_t              s1_op_q, op_d;
  logic [IDX_W-1:0] s1_idx_q, idx_d;
  logic             accept;

  logic [6:0] x7, chip_full, col;
  logic [5:0] y6;
  logic [3:0] xq;
  logic [2:0] yq;
  logic       in_rng;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !s1_valid_q || s1_adv_i;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_dev_q <= DEV_W'(1);
      y_dev_q <= DEV_W'(1);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_X_DEVICES) x_dev_q <= cfg_i.data;
      if (cfg_i.index == REG_Y_DEVICES) y_dev_q <= cfg_i.data;
    end
  end

  always_comb begin
    x7 = item_i.x_position[6:0];
    y6 = item_i.y_position[5:0];
    // x / CHIP_COLUMNS by comparing against the multiples
    xq = '0;
    for (int k = 1; k < 16; k++) begin
      if (k * CHIP_COLUMNS < 128 && x7 >= 7'(k * CHIP_COLUMNS)) xq = 4'(k);
    end
    yq        = y6[5:3];
    chip_full = 7'(xq) + 7'(yq) * 7'(x_dev_q);
    col       = x7 - 7'(xq) * 7'(CHIP_COLUMNS);
    in_rng    = !item_i.x_position[7] && !item_i.y_position[6] &&
                ({1'b0, xq} < {2'b00, x_dev_q}) && (yq < y_dev_q) &&
                (chip_full < 7'(MAX_CHIPS));
    idx_d     = IDX_W'(chip_full) * IDX_W'(CHIP_COLUMNS) + IDX_W'(col);

    op_d.kind      = OP_NONE;
    op_d.chip      = chip_full[1:0];
    op_d.addr      = {col[5:0], 1'b0};
    op_d.row       = y6[2:0];
    op_d.pixel_set = item_i.pixel_set;
    op_d.data      = item_i.column_byte;
    case (item_i.mode)
      MODE_PLOT: begin
        if (in_rng) op_d.kind = OP_PLOT;
      end
      MODE_COLUMN: begin
        if (in_rng) op_d.kind = OP_COLUMN;
      end
      MODE_COMMAND: begin
        if ({2'b00, item_i.command_chip} < 4'(MAX_CHIPS)) begin
          op_d.kind = OP_COMMAND;
          op_d.chip = item_i.command_chip;
          op_d.data = item_i.command_code;
        end
      end
      default: ;
    endcase
  end

  assign rd_en_o  = accept && (op_d.kind == OP_PLOT || op_d.kind == OP_COLUMN);
  assign rd_idx_o = idx_d;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv_i) s1_valid_d = 1'b0;
    if (accept)   s1_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= op_d;
      s1_idx_q <= idx_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_op_o    = s1_op_q;
  assign s1_idx_o   = s1_idx_q;

  // a held item must not be disturbed while the serialiser is busy
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv_i |=> s1_valid_q && $stable(s1_op_q) && $stable(s1_idx_q))
    else $error("input register changed while stalled");

endmodule

>>> hdl/lmfw_shadow.sv
// Shadow column memory with read-modify-write and frame assembly.
// Depends on lmfw_pkg.
module lmfw_shadow import lmfw_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  op_t              s1_op_i,
  input  logic [IDX_W-1:0] s1_idx_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  logic             frame_free_i,
  output logic             s1_adv_o,
  output logic             ld_valid_o,
  output frame_t           ld_frame_o
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       mem_rd_q, fwd_data_q;
  logic             vld_rd_q, fwd_q;
  logic             wr_en;
  logic [7:0]       old_byte, mask, wdata;

  assign s1_adv_o   = s1_valid_i && (s1_op_i.kind == OP_NONE || frame_free_i);
  assign wr_en      = s1_adv_o && (s1_op_i.kind == OP_PLOT || s1_op_i.kind == OP_COLUMN);
  assign ld_valid_o = s1_adv_o && (s1_op_i.kind != OP_NONE);

  // entries never written read as the cleared display
  assign old_byte = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rd_q : 8'h00);
  assign mask     = 8'h01 << s1_op_i.row;

  always_comb begin
    wdata = s1_op_i.data;
    if (s1_op_i.kind == OP_PLOT) begin
      wdata = s1_op_i.pixel_set ? (old_byte | mask) : (old_byte & ~mask);
    end
    if (s1_op_i.kind == OP_COMMAND) begin
      ld_frame_o = cmd_frame(s1_op_i.chip, s1_op_i.data);
    end else begin
      ld_frame_o = write_frame(s1_op_i.chip, s1_op_i.addr, wdata);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[s1_idx_i] <= wdata;
  end

  // read at acceptance; bypass a write-back to the same column in that cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_idx_i];
      vld_rd_q   <= valid_q[rd_idx_i];
      fwd_q      <= wr_en && (s1_idx_i == rd_idx_i);
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_idx_i] <= 1'b1;
    end
  end

  a_valid_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(s1_idx_i)])
    else $error("written column not marked valid");

endmodule

>>> hdl/lmfw_serial.sv
// Frame shift register driving the serial bit channel.
// Depends on lmfw_pkg and lmfw_if.
module lmfw_serial import lmfw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ld_valid_i,
  input  frame_t     ld_frame_i,
  output logic       frame_free_o,
  lmfw_bit_if.source bit_o
);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FRAME_BITS-1:0] sh_q, sh_d;
  logic [1:0]            chip_q, chip_d;
  logic                  beat;

  assign beat         = bit_o.valid && bit_o.ready;
  assign frame_free_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && beat);

  assign bit_o.valid      = (cnt_q != '0);
  assign bit_o.chip_index = chip_q;
  assign bit_o.serial_bit = sh_q[0];
  assign bit_o.last_bit   = (cnt_q == CNT_W'(1));

  always_comb begin
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    chip_d = chip_q;
    if (beat) begin
      cnt_d = cnt_q - CNT_W'(1);
      sh_d  = sh_q >> 1;
    end
    if (ld_valid_i) begin
      cnt_d  = ld_frame_i.len;
      sh_d   = ld_frame_i.bits;
      chip_d = ld_frame_i.chip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    chip_q <= chip_d;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_valid_i |-> (cnt_q == '0) || (cnt_q == CNT_W'(1) && beat))
    else $error("frame loaded over one still being sent");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && bit_o.last_bit && !ld_valid_i |=> !bit_o.valid)
    else $error("bits continue after the last beat of a frame");

endmodule

>>> hdl/led_matrix_pixel_frame_writer.sv
// An accepted item goes into the input register; once no earlier frame is still going
// out, its frame loads into the output shift register, which offers the first bit.
// Output: one bit per beat from the shift register, 18 bits per write, 12 per command;
// the next item waits in the input register, and items with no result pass without a frame.
// Reset: tiling returns to one by one chip; the shadow memory reads as cleared via
// per-column valid flops, so no clearing pass is needed and items are taken at once.
module led_matrix_pixel_frame_writer import lmfw_pkg::*; #(
  parameter int CHIP_COLUMNS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmfw_item_if.sink  item_i,
  lmfw_cfg_if.sink   cfg_i,
  lmfw_bit_if.source bit_o
);

  localparam int DEPTH = MAX_CHIPS * CHIP_COLUMNS;
  localparam int IDX_W = $clog2(DEPTH);

  logic             s1_adv, s1_valid, rd_en, ld_valid, frame_free;
  op_t              s1_op;
  logic [IDX_W-1:0] s1_idx, rd_idx;
  frame_t           ld_frame;

  lmfw_front #(
    .CHIP_COLUMNS (CHIP_COLUMNS),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_i      (cfg_i),
    .s1_adv_i   (s1_adv),
    .s1_valid_o (s1_valid),
    .s1_op_o    (s1_op),
    .s1_idx_o   (s1_idx),
    .rd_en_o    (rd_en),
    .rd_idx_o   (rd_idx)
  );

  lmfw_shadow #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_shadow (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_op_i      (s1_op),
    .s1_idx_i     (s1_idx),
    .rd_en_i      (rd_en),
    .rd_idx_i     (rd_idx),
    .frame_free_i (frame_free),
    .s1_adv_o     (s1_adv),
    .ld_valid_o   (ld_valid),
    .ld_frame_o   (ld_frame)
  );

  lmfw_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_valid_i   (ld_valid),
    .ld_frame_i   (ld_frame),
    .frame_free_o (frame_free),
    .bit_o        (bit_o)
  );

endmodule

>>> test/led_matrix_pixel_frame_writer_checker.sv
// Checker for the LED matrix frame writer: watches the item, register and bit channels,
// keeps its own shadow copy and tiling, predicts the serial beats and compares them.
// Depends on lmfw_pkg and the channel interfaces in lmfw_if.sv.
module led_matrix_pixel_frame_writer_checker import lmfw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lmfw_item_if  item_mon,
  lmfw_cfg_if   cfg_mon,
  lmfw_bit_if   bit_mon,
  output int    mismatch_count,
  output int    bits_pending,
  output int    bits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHIPS   = 4;
  localparam int COLUMNS = 32;
  localparam int ROWS    = 8;
  localparam logic [2:0] WRITE_HEAD = 3'b101;
  localparam logic [2:0] CMD_HEAD   = 3'b100;

  typedef struct packed {
    logic [1:0] chip;
    logic       data;
    logic       last;
  } serial_beat_t;

  serial_beat_t expected_beats_q[$];
  logic [7:0]   shadow_bytes [CHIPS*COLUMNS];
  int           x_dev;
  int           y_dev;

  function automatic void push_beat(logic [1:0] chip, logic data, logic last);
    serial_beat_t b;
    b.chip = chip;
    b.data = data;
    b.last = last;
    expected_beats_q.push_back(b);
  endfunction

  function automatic void predict_frame(logic [1:0] mode, logic [7:0] x, logic [6:0] y,
                                        logic pix, logic [7:0] col_byte,
                                        logic [1:0] cmd_chip, logic [7:0] code);
    int         xi, yi, chip, column, slot;
    logic [7:0] data;
    logic [6:0] addr;
    if (mode == MODE_COMMAND) begin
      for (int b = 2; b >= 0; b--) push_beat(cmd_chip, CMD_HEAD[b], 1'b0);
      for (int b = 7; b >= 0; b--) push_beat(cmd_chip, code[b], 1'b0);
      push_beat(cmd_chip, 1'b0, 1'b1);
      return;
    end
    if (mode != MODE_PLOT && mode != MODE_COLUMN) return;
    // sign bits mark a negative coordinate
    if (x[7] || y[6]) return;
    xi = int'(x);
    yi = int'(y);
    if (xi >= COLUMNS * x_dev || yi >= ROWS * y_dev) return;
    chip = xi / COLUMNS + (yi / ROWS) * x_dev;
    // oversized tiling can point past the last chip
    if (chip >= CHIPS) return;
    column = xi % COLUMNS;
    slot   = chip * COLUMNS + column;
    if (mode == MODE_PLOT) shadow_bytes[slot][yi % ROWS] = pix;
    else shadow_bytes[slot] = col_byte;
    data = shadow_bytes[slot];
    addr = 7'(column * 2);
    for (int b = 2; b >= 0; b--) push_beat(2'(chip), WRITE_HEAD[b], 1'b0);
    for (int b = 6; b >= 0; b--) push_beat(2'(chip), addr[b], 1'b0);
    for (int b = 0; b < 8; b++) push_beat(2'(chip), data[b], b == 7);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    serial_beat_t got;
    serial_beat_t want;
    if (!rst_ni) begin
      foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
      x_dev = 1;
      y_dev = 1;
      expected_beats_q.delete();
      bits_pending = 0;
    end else begin
      // beats first: a beat at this edge always belongs to an earlier item
      if (bit_mon.valid && bit_mon.ready) begin
        got.chip = bit_mon.chip_index;
        got.data = bit_mon.serial_bit;
        got.last = bit_mon.last_bit;
        bits_checked++;
        if (expected_beats_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat: expected none, got chip %0d bit %0b last %0b",
                   $time, got.chip, got.data, got.last);
        end else begin
          want = expected_beats_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: beat mismatch: expected %0d/%0b/%0b (chip/bit/last), got %0d/%0b/%0b",
                     $time, want.chip, want.data, want.last, got.chip, got.data, got.last);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_X_DEVICES) x_dev = int'(cfg_mon.data);
        else if (cfg_mon.index == REG_Y_DEVICES) y_dev = int'(cfg_mon.data);
      end
      if (item_mon.valid && item_mon.ready)
        predict_frame(item_mon.mode, item_mon.x_position, item_mon.y_position,
                      item_mon.pixel_set, item_mon.column_byte,
                      item_mon.command_chip, item_mon.command_code);
      bits_pending = expected_beats_q.size();
    end
  end

endmodule

>>> test/led_matrix_pixel_frame_writer_tb.sv
// Top of the frame writer testbench: clock, reset, register writes, item stimulus and
// receiver stalls; the checker beside the block does all prediction and comparison.
// Depends on lmfw_pkg, lmfw_if.sv, the block and led_matrix_pixel_frame_writer_checker.
module led_matrix_pixel_frame_writer_tb import lmfw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           MODE_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd2;
  localparam int IDLE_LIMIT     = 2000;
  localparam int LONG_STALL     = 300;
  localparam int PHASE_ITEMS    = 40;
  localparam int SETTINGS_COUNT = 10;

  logic clk_i;
  logic rst_ni;
  logic long_stall_req;
  int   mismatch_count;
  int   bits_pending;
  int   bits_checked;
  int   plot_items, column_items, command_items, unused_items;

  lmfw_item_if item_if ();
  lmfw_cfg_if  cfg_if ();
  lmfw_bit_if  bit_if ();

  led_matrix_pixel_frame_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .cfg_i  (cfg_if),
    .bit_o  (bit_if)
  );

  led_matrix_pixel_frame_writer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_mon       (item_if),
    .cfg_mon        (cfg_if),
    .bit_mon        (bit_if),
    .mismatch_count (mismatch_count),
    .bits_pending   (bits_pending),
    .bits_checked   (bits_checked)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // all drive tasks enter and leave on a falling edge
  task automatic send_item(logic [1:0] mode, logic [7:0] x, logic [6:0] y, logic pix,
                           logic [7:0] col_byte, logic [1:0] cmd_chip, logic [7:0] code);
    item_if.mode         = mode;
    item_if.x_position   = x;
    item_if.y_position   = y;
    item_if.pixel_set    = pix;
    item_if.column_byte  = col_byte;
    item_if.command_chip = cmd_chip;
    item_if.command_code = code;
    item_if.valid        = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
    case (mode)
      MODE_PLOT:    plot_items++;
      MODE_COLUMN:  column_items++;
      MODE_COMMAND: command_items++;
      default:      unused_items++;
    endcase
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      item_if.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DEV_W-1:0] data);
    cfg_if.index = index;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // wait for every expected beat, then allow for a result-less item still in flight
  task automatic drain_frames();
    item_if.valid = 1'b0;
    while (bits_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_item(int xd, int yd);
    logic [1:0] mode;
    logic [7:0] x;
    logic [6:0] y;
    int         roll, xspan, yspan;
    roll = $urandom_range(0, 99);
    if (roll < 40) mode = MODE_PLOT;
    else if (roll < 75) mode = MODE_COLUMN;
    else if (roll < 95) mode = MODE_COMMAND;
    else mode = MODE_UNUSED;
    x = 8'($urandom);
    y = 7'($urandom);
    xspan = (32 * xd > 128) ? 128 : 32 * xd;
    yspan = (8 * yd > 64) ? 64 : 8 * yd;
    if (xspan > 0 && yspan > 0 && $urandom_range(0, 99) < 85) begin
      // a narrow column band makes read-modify-write hit the same bytes again
      if ($urandom_range(0, 3) == 0) x = 8'($urandom_range(0, (xspan < 4 ? xspan : 4) - 1));
      else x = 8'($urandom_range(0, xspan - 1));
      y = 7'($urandom_range(0, yspan - 1));
    end
    send_item(mode, x, y, 1'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic run_setting(int xd, int yd, int count);
    int sent;
    int burst;
    drain_frames();
    write_reg(REG_X_DEVICES, DEV_W'(xd));
    write_reg(REG_Y_DEVICES, DEV_W'(yd));
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        random_item(xd, yd);
        burst--;
        sent++;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end
  endtask

  // receiver: segments of always ready, random, mostly stalled or a short hold
  initial begin
    int  kind;
    int  len;
    int  hold;
    bit  stall_taken;
    bit_if.ready = 1'b0;
    stall_taken  = 1'b0;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      if (long_stall_req && !stall_taken) begin
        bit_if.ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk_i);
        stall_taken = 1'b1;
      end
      kind = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      hold = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0:       bit_if.ready = 1'b1;
          1:       bit_if.ready = 1'($urandom);
          2:       bit_if.ready = ($urandom_range(0, 4) == 0);
          default: bit_if.ready = (i >= hold);
        endcase
        @(negedge clk_i);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (bit_if.valid && bit_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int setting_x [SETTINGS_COUNT];
    int setting_y [SETTINGS_COUNT];
    setting_x = '{1, 4, 1, 2, 4, 0, 3, 7, 2, 1};
    setting_y = '{1, 1, 4, 2, 2, 3, 1, 7, 0, 1};
    rst_ni               = 1'b0;
    long_stall_req       = 1'b0;
    item_if.valid        = 1'b0;
    item_if.mode         = MODE_PLOT;
    item_if.x_position   = '0;
    item_if.y_position   = '0;
    item_if.pixel_set    = 1'b0;
    item_if.column_byte  = '0;
    item_if.command_chip = '0;
    item_if.command_code = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_X_DEVICES;
    cfg_if.data          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: two by two tiling so every chip is reachable
    write_reg(REG_UNMAPPED, DEV_W'($urandom));
    write_reg(REG_X_DEVICES, 3'd2);
    write_reg(REG_Y_DEVICES, 3'd2);
    send_item(MODE_PLOT,    8'd0,   7'd0,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd0,   7'd7,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd0,   7'd0,    1'b0, 8'hFF, 2'd3, 8'hFF);
    send_item(MODE_PLOT,    8'd63,  7'd15,   1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd32,  7'd8,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_COLUMN,  8'd31,  7'd8,    1'b0, 8'hFF, 2'd0, 8'h00);
    send_item(MODE_COLUMN,  8'd31,  7'd8,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_COLUMN,  8'd40,  7'd3,    1'b0, 8'hA5, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd40,  7'd6,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd64,  7'd0,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd0,   7'd16,   1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'hFF,  7'd0,    1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'h80,  7'h40,   1'b1, 8'h00, 2'd0, 8'h00);
    send_item(MODE_COLUMN,  8'd127, 7'd63,   1'b1, 8'hFF, 2'd0, 8'h00);
    send_item(MODE_COLUMN,  8'd5,   7'h7F,   1'b1, 8'hFF, 2'd0, 8'h00);
    send_item(MODE_COMMAND, 8'd0,   7'd0,    1'b0, 8'h00, 2'd0, 8'h00);
    send_item(MODE_COMMAND, 8'hFF,  7'h7F,   1'b1, 8'hFF, 2'd3, 8'hFF);
    send_item(MODE_COMMAND, 8'd10,  7'd2,    1'b0, 8'h00, 2'd1, 8'h5A);
    send_item(MODE_COMMAND, 8'd10,  7'd2,    1'b0, 8'h00, 2'd2, 8'h81);
    send_item(MODE_UNUSED,  8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom),
              2'($urandom), 8'($urandom));
    send_item(MODE_COLUMN,  8'd63,  7'd0,    1'b0, 8'hFF, 2'd0, 8'h00);
    send_item(MODE_PLOT,    8'd63,  7'd0,    1'b0, 8'h00, 2'd0, 8'h00);

    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      // one long receiver hold while the sender keeps offering items
      if (s == 2) begin
        drain_frames();
        long_stall_req = 1'b1;
      end
      run_setting(setting_x[s], setting_y[s], PHASE_ITEMS);
    end

    drain_frames();
    repeat (10) @(negedge clk_i);
    $display("Run covered %0d items: %0d plot, %0d column, %0d command, %0d unused mode",
             plot_items + column_items + command_items + unused_items,
             plot_items, column_items, command_items, unused_items);
    $display("%0d tiling settings including zero and oversized, %0d serial beats checked",
             SETTINGS_COUNT + 1, bits_checked);
    if (mismatch_count == 0 && bits_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
